/* rtl/bam_aux_field_walker_assert.svh */
// Assertion macros used by the auxiliary field walker top level.
`ifndef BAM_AUX_FIELD_WALKER_ASSERT_SVH
`define BAM_AUX_FIELD_WALKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BAW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BAW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/baw_pkg.sv */
// Types, codes and helpers for the auxiliary field walker.
package baw_pkg;

    // Type characters
    localparam logic [7:0] CH_A_UPPER = 8'h41;
    localparam logic [7:0] CH_C_LOWER = 8'h63;
    localparam logic [7:0] CH_C_UPPER = 8'h43;
    localparam logic [7:0] CH_S_LOWER = 8'h73;
    localparam logic [7:0] CH_S_UPPER = 8'h53;
    localparam logic [7:0] CH_I_LOWER = 8'h69;
    localparam logic [7:0] CH_I_UPPER = 8'h49;
    localparam logic [7:0] CH_F_LOWER = 8'h66;
    localparam logic [7:0] CH_D_LOWER = 8'h64;
    localparam logic [7:0] CH_Z_UPPER = 8'h5A;
    localparam logic [7:0] CH_H_UPPER = 8'h48;
    localparam logic [7:0] CH_B_UPPER = 8'h42;

    localparam logic [30:0] PAYLOAD_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_NO_TYPE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_TAG0    = 4'd0,
        PH_TAG1    = 4'd1,
        PH_TYPE    = 4'd2,
        PH_FIXED   = 4'd3,
        PH_STRING  = 4'd4,
        PH_SUBTYPE = 4'd5,
        PH_COUNT   = 4'd6,
        PH_ARRAY   = 4'd7
    } phase_t;

    // One registered input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } step_t;

    // One field description
    typedef struct packed {
        logic [15:0] tag_code;
        logic [7:0]  type_code;
        logic [7:0]  array_subtype;
        logic [31:0] element_count;
        logic [30:0] payload_bytes;
        status_t     status;
        logic        record_end;
    } result_t;

    // Payload size of a fixed type, zero for anything else
    function automatic logic [3:0] fixed_size(input logic [7:0] t);
        logic [3:0] sz;
        begin
            sz = 4'd0;
            if (t == CH_A_UPPER || t == CH_C_LOWER || t == CH_C_UPPER) begin
                sz = 4'd1;
            end
            else if (t == CH_S_LOWER || t == CH_S_UPPER) begin
                sz = 4'd2;
            end
            else if (t == CH_I_LOWER || t == CH_I_UPPER || t == CH_F_LOWER) begin
                sz = 4'd4;
            end
            else if (t == CH_D_LOWER) begin
                sz = 4'd8;
            end
            return sz;
        end
    endfunction

endpackage

/* rtl/baw_in_reg.sv */
// Input register stage: holds one byte until the field logic takes it.
module baw_in_reg
    import baw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       take,
    output logic       step_valid,
    output step_t      step
);

    logic  valid_reg;
    logic  valid_next;
    step_t step_reg;

    // Accept when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            step_reg.data_byte <= data_byte;
            step_reg.last_byte <= last_byte;
        end
    end

    assign step_valid = valid_reg;
    assign step       = step_reg;

endmodule

/* rtl/baw_core.sv */
// Field phase machine: walks tag, type, payload and array header bytes.
module baw_core
    import baw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  step_t   step,
    output logic    emit,
    output result_t result
);

    phase_t      ph_reg,   ph_next,   ph_w;
    logic [15:0] tag_reg,  tag_next,  tag_w;
    logic [7:0]  typ_reg,  typ_next,  typ_w;
    logic [7:0]  sub_reg,  sub_next,  sub_w;
    logic [3:0]  esz_reg,  esz_next,  esz_w;
    logic [31:0] cnt_reg,  cnt_next,  cnt_w;
    logic [1:0]  cidx_reg, cidx_next, cidx_w;
    logic [34:0] rem_reg,  rem_next,  rem_w;
    logic [30:0] pay_reg,  pay_next,  pay_w;
    logic        disc_reg, disc_next;

    logic [7:0]  b;
    logic        last;
    logic [30:0] pay_inc;
    logic [34:0] rem_dec;
    logic [34:0] arr_bytes;
    logic [3:0]  sz;
    status_t     st;

    assign b    = step.data_byte;
    assign last = step.last_byte;

    // Saturating payload count and remaining-bytes decrement
    assign pay_inc = (pay_reg == PAYLOAD_MAX) ? pay_reg : pay_reg + 31'd1;
    assign rem_dec = (rem_reg != 35'd0) ? rem_reg - 35'd1 : rem_reg;

    // Next state and field result
    always_comb
    begin
        ph_w      = ph_reg;
        tag_w     = tag_reg;
        typ_w     = typ_reg;
        sub_w     = sub_reg;
        esz_w     = esz_reg;
        cnt_w     = cnt_reg;
        cidx_w    = cidx_reg;
        rem_w     = rem_reg;
        pay_w     = pay_reg;
        disc_next = disc_reg;
        emit      = 1'b0;
        st        = ST_OK;
        sz        = fixed_size(b);
        arr_bytes = 35'd0;

        if (go && disc_reg)
        begin
            // Drop the rest of the record
            disc_next = !last;
            ph_w   = PH_TAG0;
            tag_w  = '0;
            typ_w  = '0;
            sub_w  = '0;
            esz_w  = '0;
            cnt_w  = '0;
            cidx_w = '0;
            rem_w  = '0;
            pay_w  = '0;
        end
        else if (go)
        begin
            unique case (ph_reg)
                PH_TAG0:
                begin
                    tag_w = {b, 8'h00};
                    if (last) begin emit = 1'b1; st = ST_NO_TYPE; end
                    else ph_w = PH_TAG1;
                end
                PH_TAG1:
                begin
                    tag_w = {tag_reg[15:8], b};
                    if (last) begin emit = 1'b1; st = ST_NO_TYPE; end
                    else ph_w = PH_TYPE;
                end
                PH_TYPE:
                begin
                    typ_w = b;
                    if (b == CH_Z_UPPER || b == CH_H_UPPER)
                    begin
                        if (last) begin emit = 1'b1; st = ST_OK; end
                        else ph_w = PH_STRING;
                    end
                    else if (b == CH_B_UPPER)
                    begin
                        if (last) begin emit = 1'b1; st = ST_TRUNC; end
                        else ph_w = PH_SUBTYPE;
                    end
                    else if (sz == 4'd0)
                    begin
                        emit = 1'b1;
                        st   = ST_UNKNOWN;
                    end
                    else
                    begin
                        rem_w = {31'd0, sz};
                        if (last) begin emit = 1'b1; st = ST_TRUNC; end
                        else ph_w = PH_FIXED;
                    end
                end
                PH_FIXED, PH_ARRAY:
                begin
                    pay_w = pay_inc;
                    rem_w = rem_dec;
                    if (rem_dec == 35'd0) begin emit = 1'b1; st = ST_OK; end
                    else if (last) begin emit = 1'b1; st = ST_TRUNC; end
                end
                PH_STRING:
                begin
                    pay_w = pay_inc;
                    if (b == 8'h00 || last) begin emit = 1'b1; st = ST_OK; end
                end
                PH_SUBTYPE:
                begin
                    pay_w  = pay_inc;
                    sub_w  = b;
                    esz_w  = sz;
                    cnt_w  = '0;
                    cidx_w = '0;
                    if (last) begin emit = 1'b1; st = ST_TRUNC; end
                    else ph_w = PH_COUNT;
                end
                PH_COUNT:
                begin
                    pay_w = pay_inc;
                    // Merge the count byte into its little-endian lane
                    unique case (cidx_reg)
                        2'd0: cnt_w = {cnt_reg[31:8], b};
                        2'd1: cnt_w = {cnt_reg[31:16], b, cnt_reg[7:0]};
                        2'd2: cnt_w = {cnt_reg[31:24], b, cnt_reg[15:0]};
                        default: cnt_w = {b, cnt_reg[23:0]};
                    endcase
                    // Element sizes are powers of two: scale by shifting
                    unique case (esz_reg)
                        4'd1: arr_bytes = {3'd0, cnt_w};
                        4'd2: arr_bytes = {2'd0, cnt_w, 1'b0};
                        4'd4: arr_bytes = {1'd0, cnt_w, 2'd0};
                        4'd8: arr_bytes = {cnt_w, 3'd0};
                        default: arr_bytes = 35'd0;
                    endcase
                    if (cidx_reg == 2'd3)
                    begin
                        rem_w = arr_bytes;
                        if (esz_reg == 4'd0) begin emit = 1'b1; st = ST_UNKNOWN; end
                        else if (arr_bytes == 35'd0) begin emit = 1'b1; st = ST_OK; end
                        else if (last) begin emit = 1'b1; st = ST_TRUNC; end
                        else ph_w = PH_ARRAY;
                    end
                    else
                    begin
                        cidx_w = cidx_reg + 2'd1;
                        if (last) begin emit = 1'b1; st = ST_TRUNC; end
                    end
                end
                default:
                begin
                    ph_w   = PH_TAG0;
                    tag_w  = '0;
                    typ_w  = '0;
                    sub_w  = '0;
                    esz_w  = '0;
                    cnt_w  = '0;
                    cidx_w = '0;
                    rem_w  = '0;
                    pay_w  = '0;
                end
            endcase
        end

        // Describe the closed field
        result.tag_code      = tag_w;
        result.type_code     = typ_w;
        result.array_subtype = sub_w;
        result.element_count = cnt_w;
        result.payload_bytes = pay_w;
        result.status        = st;
        result.record_end    = last;

        if (emit)
        begin
            ph_next   = PH_TAG0;
            tag_next  = '0;
            typ_next  = '0;
            sub_next  = '0;
            esz_next  = '0;
            cnt_next  = '0;
            cidx_next = '0;
            rem_next  = '0;
            pay_next  = '0;
            disc_next = (st == ST_UNKNOWN) && !last;
        end
        else
        begin
            ph_next   = ph_w;
            tag_next  = tag_w;
            typ_next  = typ_w;
            sub_next  = sub_w;
            esz_next  = esz_w;
            cnt_next  = cnt_w;
            cidx_next = cidx_w;
            rem_next  = rem_w;
            pay_next  = pay_w;
        end
    end

    // Field state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_TAG0;
            tag_reg  <= '0;
            typ_reg  <= '0;
            sub_reg  <= '0;
            esz_reg  <= '0;
            cnt_reg  <= '0;
            cidx_reg <= '0;
            rem_reg  <= '0;
            pay_reg  <= '0;
            disc_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            tag_reg  <= tag_next;
            typ_reg  <= typ_next;
            sub_reg  <= sub_next;
            esz_reg  <= esz_next;
            cnt_reg  <= cnt_next;
            cidx_reg <= cidx_next;
            rem_reg  <= rem_next;
            pay_reg  <= pay_next;
            disc_reg <= disc_next;
        end
    end

endmodule

/* rtl/baw_out_reg.sv */
// Result register: holds one field description until the receiver takes it.
module baw_out_reg
    import baw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  logic    emit,
    input  result_t result,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t held
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or when the held transaction leaves this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = can_load ? (go && emit) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new result
    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = res_reg;

endmodule

/* rtl/bam_aux_field_walker.sv */
// Top level: walks the auxiliary area of a BAM record and reports each field.
// Input channel: one byte of the auxiliary area per transaction (data_byte),
// with last_byte high on the final byte of the record. Output channel: one
// transaction per closed field with tag, type, array subtype and element
// count, payload length (saturating) and a status code; record_end marks a
// result taken on the record's last byte.
// Path: a byte accepted into the input register runs through the phase
// machine once the result register can take its outcome, and that outcome
// is registered in the result register, which drives out_valid.
// Throughput: one byte per cycle while no result is stalled, set by the
// phase machine between the input register and the result register.
// Reset: both registers empty, phase machine waiting for the first tag byte.
// Stall: while a result waits with out_ready low, the phase machine holds;
// one more byte can sit in the input register, then in_ready drops until the
// result is taken.
// After an unknown type on a byte that is not the last, bytes up to and
// including the record's last byte produce no results.
`include "bam_aux_field_walker_assert.svh"

module bam_aux_field_walker
    import baw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] tag_code,
    output logic [7:0]  type_code,
    output logic [7:0]  array_subtype,
    output logic [31:0] element_count,
    output logic [30:0] payload_bytes,
    output logic [1:0]  status,
    output logic        record_end
);

    logic    step_valid;
    step_t   step;
    logic    can_load;
    logic    go;
    logic    emit;
    result_t result;
    result_t held;

    // Advance a byte only when the result register can take its outcome
    assign go = step_valid && can_load;

    baw_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .take       (go),
        .step_valid (step_valid),
        .step       (step)
    );

    baw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .step   (step),
        .emit   (emit),
        .result (result)
    );

    baw_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .emit      (emit),
        .result    (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    // Unpack the held result onto the output fields
    assign tag_code      = held.tag_code;
    assign type_code     = held.type_code;
    assign array_subtype = held.array_subtype;
    assign element_count = held.element_count;
    assign payload_bytes = held.payload_bytes;
    assign status        = held.status;
    assign record_end    = held.record_end;

    // A record ending before the type byte always closes the record
    `BAW_ASSERT_IMP(a_no_type_ends, out_valid && (status == ST_NO_TYPE), record_end, "no-type status without record end")
    // Truncation only happens at record end
    `BAW_ASSERT_IMP(a_trunc_ends, out_valid && (status == ST_TRUNC), record_end, "truncated status without record end")
    // Only arrays carry an element count
    `BAW_ASSERT_IMP(a_count_array, out_valid && (element_count != 32'd0), type_code == CH_B_UPPER, "element count on a non-array field")
    // Input backpressure comes only from a stalled result
    `BAW_ASSERT_IMP(a_ready_cause, !in_ready, out_valid && !out_ready, "input stalled without output stall")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the BAM auxiliary field walker.
module testbench
    import baw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Type byte that no field type uses
    localparam logic [7:0] CH_BAD_TYPE = 8'h51;
    // Receiver hold-off length, in cycles
    localparam int HOLD_CYCLES = 400;
    // Bytes of random records per idling phase
    localparam int PHASE_BYTES = 620;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] tag_code;
    logic [7:0]  type_code;
    logic [7:0]  array_subtype;
    logic [31:0] element_count;
    logic [30:0] payload_bytes;
    logic [1:0]  status;
    logic        record_end;

    bam_aux_field_walker uut (.*);

    // Directed stimulus row; typed rows carry their own expectation, a field or none
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        bit         has_res;
        result_t    res;
    } dir_row_t;

    dir_row_t   dir_rows[$];
    result_t    pending_fields[$];
    logic [7:0] rec_q[$];
    result_t    field_want;
    int         mismatch_count = 0;
    int         tx_pct = 10;
    int         rx_pct = 82;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         hold_left = 0;

    // Walker state of the predictor
    phase_t      walk_phase;
    logic [15:0] walk_tag;
    logic [7:0]  walk_type;
    logic [7:0]  walk_sub;
    logic [3:0]  walk_esize;
    logic [31:0] walk_count;
    logic [1:0]  walk_cidx;
    logic [34:0] walk_left;
    logic [30:0] walk_pay;
    bit          walk_skip;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append one byte to the record under construction
    function automatic void rec_add(input logic [7:0] v);
        rec_q.insert(rec_q.size(), v);
    endfunction

    // Queue one expected field behind those already waiting
    function automatic void expect_add(input result_t r);
        pending_fields.insert(pending_fields.size(), r);
    endfunction

    function automatic logic [3:0] type_width(input logic [7:0] t);
        case (t)
            CH_A_UPPER, CH_C_LOWER, CH_C_UPPER: return 4'd1;
            CH_S_LOWER, CH_S_UPPER:             return 4'd2;
            CH_I_LOWER, CH_I_UPPER, CH_F_LOWER: return 4'd4;
            CH_D_LOWER:                         return 4'd8;
            default:                            return 4'd0;
        endcase
    endfunction

    function automatic void clear_field();
        walk_phase = PH_TAG0;
        walk_tag   = '0;
        walk_type  = '0;
        walk_sub   = '0;
        walk_esize = '0;
        walk_count = '0;
        walk_cidx  = '0;
        walk_left  = '0;
        walk_pay   = '0;
    endfunction

    // Describe the open field, then start a new one
    function automatic result_t close_field(input status_t st, input logic last);
        result_t r;
        r.tag_code      = walk_tag;
        r.type_code     = walk_type;
        r.array_subtype = walk_sub;
        r.element_count = walk_count;
        r.payload_bytes = walk_pay;
        r.status        = st;
        r.record_end    = last;
        clear_field();
        walk_skip = (st == ST_UNKNOWN) && !last;
        return r;
    endfunction

    function automatic void bump_pay();
        if (walk_pay != PAYLOAD_MAX)
        begin
            walk_pay = walk_pay + 31'd1;
        end
    endfunction

    // Advance the predictor by one byte; return 1 when a field closes
    function automatic bit walk_byte(input logic [7:0] b, input logic last,
                                     output result_t r);
        logic [3:0] sz;
        r = '0;
        if (walk_skip)
        begin
            if (last)
            begin
                walk_skip = 1'b0;
            end
            clear_field();
            return 1'b0;
        end
        case (walk_phase)
            PH_TAG0:
            begin
                walk_tag = {b, 8'h00};
                if (last)
                begin
                    r = close_field(ST_NO_TYPE, 1'b1);
                    return 1'b1;
                end
                walk_phase = PH_TAG1;
            end
            PH_TAG1:
            begin
                walk_tag[7:0] = b;
                if (last)
                begin
                    r = close_field(ST_NO_TYPE, 1'b1);
                    return 1'b1;
                end
                walk_phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                walk_type = b;
                if (b == CH_Z_UPPER || b == CH_H_UPPER)
                begin
                    if (last)
                    begin
                        r = close_field(ST_OK, 1'b1);
                        return 1'b1;
                    end
                    walk_phase = PH_STRING;
                    return 1'b0;
                end
                if (b == CH_B_UPPER)
                begin
                    if (last)
                    begin
                        r = close_field(ST_TRUNC, 1'b1);
                        return 1'b1;
                    end
                    walk_phase = PH_SUBTYPE;
                    return 1'b0;
                end
                sz = type_width(b);
                if (sz == 4'd0)
                begin
                    r = close_field(ST_UNKNOWN, last);
                    return 1'b1;
                end
                walk_left = {31'd0, sz};
                if (last)
                begin
                    r = close_field(ST_TRUNC, 1'b1);
                    return 1'b1;
                end
                walk_phase = PH_FIXED;
            end
            PH_FIXED, PH_ARRAY:
            begin
                bump_pay();
                if (walk_left != '0)
                begin
                    walk_left = walk_left - 35'd1;
                end
                if (walk_left == '0)
                begin
                    r = close_field(ST_OK, last);
                    return 1'b1;
                end
                if (last)
                begin
                    r = close_field(ST_TRUNC, 1'b1);
                    return 1'b1;
                end
            end
            PH_STRING:
            begin
                bump_pay();
                if (b == 8'h00 || last)
                begin
                    r = close_field(ST_OK, last);
                    return 1'b1;
                end
            end
            PH_SUBTYPE:
            begin
                bump_pay();
                walk_sub   = b;
                walk_esize = type_width(b);
                walk_count = '0;
                walk_cidx  = '0;
                if (last)
                begin
                    r = close_field(ST_TRUNC, 1'b1);
                    return 1'b1;
                end
                walk_phase = PH_COUNT;
            end
            PH_COUNT:
            begin
                bump_pay();
                walk_count = walk_count | ({24'd0, b} << (8 * walk_cidx));
                if (walk_cidx == 2'd3)
                begin
                    if (walk_esize == 4'd0)
                    begin
                        r = close_field(ST_UNKNOWN, last);
                        return 1'b1;
                    end
                    walk_left = {31'd0, walk_esize} * {3'd0, walk_count};
                    if (walk_left == '0)
                    begin
                        r = close_field(ST_OK, last);
                        return 1'b1;
                    end
                    if (last)
                    begin
                        r = close_field(ST_TRUNC, 1'b1);
                        return 1'b1;
                    end
                    walk_phase = PH_ARRAY;
                    return 1'b0;
                end
                walk_cidx = walk_cidx + 2'd1;
                if (last)
                begin
                    r = close_field(ST_TRUNC, 1'b1);
                    return 1'b1;
                end
            end
            default:
            begin
                clear_field();
            end
        endcase
        return 1'b0;
    endfunction

    task automatic add_row(input logic [7:0] data, input logic last, input bit typed,
                           input bit has_res, input result_t res);
        dir_row_t row;
        row.data    = data;
        row.last    = last;
        row.typed   = typed;
        row.has_res = has_res;
        row.res     = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Offer one byte, wait for the transaction, then predict its field
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input bit has_res, input result_t res);
        result_t pred;
        bit      got;
        @(negedge clk);
        while (tx_pct != 0 && $urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        got = walk_byte(b, last, pred);
        if (typed)
        begin
            if (has_res)
            begin
                expect_add(res);
            end
        end
        else if (got)
        begin
            expect_add(pred);
        end
    endtask

    // Drop valid and hold until every predicted field has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_fields.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Append one well-formed field with random content
    task automatic add_field();
        logic [7:0] t;
        logic [7:0] sub;
        int         n;
        int         esz;
        int         cnt;
        rec_add(8'($urandom_range(255)));
        rec_add(8'($urandom_range(255)));
        n = 0;
        case ($urandom_range(11))
            0:  begin t = CH_A_UPPER; n = 1; end
            1:  begin t = CH_C_LOWER; n = 1; end
            2:  begin t = CH_C_UPPER; n = 1; end
            3:  begin t = CH_S_LOWER; n = 2; end
            4:  begin t = CH_S_UPPER; n = 2; end
            5:  begin t = CH_I_LOWER; n = 4; end
            6:  begin t = CH_I_UPPER; n = 4; end
            7:  begin t = CH_F_LOWER; n = 4; end
            8:  begin t = CH_D_LOWER; n = 8; end
            9:  t = CH_Z_UPPER;
            10: t = CH_H_UPPER;
            default: t = CH_B_UPPER;
        endcase
        rec_add(t);
        if (t == CH_Z_UPPER || t == CH_H_UPPER)
        begin
            repeat ($urandom_range(0, 8))
            begin
                rec_add(8'($urandom_range(1, 255)));
            end
            rec_add(8'h00);
        end
        else if (t == CH_B_UPPER)
        begin
            case ($urandom_range(7))
                0: begin sub = CH_A_UPPER; esz = 1; end
                1: begin sub = CH_C_LOWER; esz = 1; end
                2: begin sub = CH_C_UPPER; esz = 1; end
                3: begin sub = CH_S_LOWER; esz = 2; end
                4: begin sub = CH_S_UPPER; esz = 2; end
                5: begin sub = CH_I_UPPER; esz = 4; end
                6: begin sub = CH_F_LOWER; esz = 4; end
                default: begin sub = CH_D_LOWER; esz = 8; end
            endcase
            cnt = $urandom_range(0, 4);
            rec_add(sub);
            rec_add(8'(cnt));
            rec_add(8'h00);
            rec_add(8'h00);
            rec_add(8'h00);
            n = cnt * esz;
        end
        repeat (n)
        begin
            rec_add(8'($urandom_range(255)));
        end
    endtask

    // Build one record: mostly well-formed, some cut short, bad types, big arrays, noise
    task automatic make_record();
        int mode;
        int cut;
        rec_q.delete();
        mode = $urandom_range(99);
        if (mode < 97)
        begin
            repeat ($urandom_range(1, 3))
            begin
                add_field();
            end
        end
        if (mode < 70)
        begin
        end
        else if (mode < 85)
        begin
            cut = $urandom_range(1, rec_q.size());
            while (rec_q.size() > cut)
            begin
                void'(rec_q.pop_back());
            end
        end
        else if (mode < 91)
        begin
            rec_add(8'($urandom_range(255)));
            rec_add(8'($urandom_range(255)));
            rec_add(8'($urandom_range(255)));
            repeat ($urandom_range(0, 6))
            begin
                rec_add(8'($urandom_range(255)));
            end
        end
        else if (mode < 97)
        begin
            // array whose elements the record end cuts off after the count
            rec_add(8'($urandom_range(255)));
            rec_add(8'($urandom_range(255)));
            rec_add(CH_B_UPPER);
            rec_add($urandom_range(1) ? 8'($urandom_range(255)) : CH_S_UPPER);
            repeat (4)
            begin
                rec_add(8'($urandom_range(255)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                rec_add(8'($urandom_range(255)));
            end
        end
    endtask

    // Drive out_ready; serve long hold-off requests first
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_requests)
        begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_pct);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    // Compare each result transaction with the oldest predicted field
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fields.size() == 0)
            begin
                $display("%0t: unexpected field, expected none, actual tag %h type %h status %0d",
                         $time, tag_code, type_code, status);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                field_want = pending_fields.pop_front();
                check_field("tag_code", field_want.tag_code, tag_code);
                check_field("type_code", field_want.type_code, type_code);
                check_field("array_subtype", field_want.array_subtype, array_subtype);
                check_field("element_count", field_want.element_count, element_count);
                check_field("payload_bytes", field_want.payload_bytes, payload_bytes);
                check_field("status", field_want.status, status);
                check_field("record_end", field_want.record_end, record_end);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int ph;
        int sent;
        bit held;
        bit drained;
        clear_field();
        walk_skip = 1'b0;

        // Directed records
        add_row(8'h58, 1'b1, 1'b1, 1'b1, result_t'{16'h5800, 8'h00, 8'h00, 32'h0, 31'd0,
                                                   ST_NO_TYPE, 1'b1});
        add_row(8'h58, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h59, 1'b1, 1'b1, 1'b1, result_t'{16'h5859, 8'h00, 8'h00, 32'h0, 31'd0,
                                                   ST_NO_TYPE, 1'b1});
        add_row(8'h41, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h42, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_BAD_TYPE, 1'b0, 1'b1, 1'b1, result_t'{16'h4142, CH_BAD_TYPE, 8'h00,
                                                         32'h0, 31'd0, ST_UNKNOWN, 1'b0});
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_Z_UPPER, 1'b1, 1'b1, 1'b1, result_t'{16'hFF00, CH_Z_UPPER, 8'h00,
                                                        32'h0, 31'd0, ST_OK, 1'b1});
        add_row(8'h4E, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h4D, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_B_UPPER, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_I_LOWER, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, 1'b1, result_t'{16'h4E4D, CH_B_UPPER, CH_I_LOWER,
                                                   32'hFFFF_FFFF, 31'd5, ST_TRUNC, 1'b1});
        add_row(8'h58, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h58, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_B_UPPER, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_Z_UPPER, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, 1'b1, result_t'{16'h5858, CH_B_UPPER, CH_Z_UPPER,
                                                   32'h0000_0001, 31'd5, ST_UNKNOWN, 1'b1});

        // Hold reset, then release it on a falling clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].has_res, dir_rows[i].res);
        end

        // Random records under three idling patterns
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin tx_pct = 10; rx_pct = 82; end
                1: begin tx_pct = 82; rx_pct = 10; end
                default: begin tx_pct = 0; rx_pct = 0; end
            endcase
            sent    = 0;
            held    = 1'b0;
            drained = 1'b0;
            while (sent < PHASE_BYTES)
            begin
                make_record();
                foreach (rec_q[i])
                begin
                    send_byte(rec_q[i], i == rec_q.size() - 1, 1'b0, 1'b0, '0);
                end
                sent = sent + rec_q.size();
                if (ph == 0 && !held && sent > 300)
                begin
                    hold_requests = hold_requests + 1;
                    held = 1'b1;
                end
                if (ph == 1 && !drained && sent > 300)
                begin
                    wait_drained();
                    drained = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
